// File: src/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_BRIGHT = 3'd1,
    REQ_FIRE   = 3'd2,
    REQ_SMOOTH = 3'd3,
    REQ_AIM    = 3'd4
  } req_e_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_ON     = 2'd2
  } phase_t;

  // configuration register indexes
  localparam logic CFG_SETTLE  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] SETTLE_RST     = 16'd200;
  localparam logic [31:0] TIMEOUT_RST    = 32'd10000;
  localparam logic [31:0] FIRE_DEFAULT   = 32'd500;
  localparam logic [15:0] MIN_STEP       = 16'd5;
  localparam logic [6:0]  POS_MAX        = 7'd100;
  localparam logic [6:0]  POS_HOME       = 7'd50;
  localparam logic [7:0]  DUTY_FULL      = 8'd255;
  localparam logic [15:0] SLEW_PERIOD_RST = 16'd30;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [31:0]       now_ms;
    logic signed [7:0] pan_req;
    logic signed [7:0] tilt_req;
    logic [31:0]       duration_ms;
    logic [15:0]       step_period_ms;
    logic [7:0]        brightness_req;
  } item_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic        emitting;
    logic [31:0] on_since;
    phase_t      phase;
    logic [31:0] phase_start;
    logic [31:0] fire_len;
    logic [6:0]  slew_pan;
    logic [6:0]  slew_tilt;
    logic [6:0]  goal_pan;
    logic [6:0]  goal_tilt;
    logic        slew_active;
    logic [15:0] slew_period;
    logic [31:0] last_step;
    logic [6:0]  servo_pan;
    logic [6:0]  servo_tilt;
  } state_t;

  typedef struct packed {
    logic [7:0] laser_duty;
    logic [6:0] pan_cmd;
    logic [6:0] tilt_cmd;
    logic       servo_written;
    logic [1:0] fire_state;
    logic       fire_rejected;
    logic       safety_tripped;
    logic       is_emitting;
  } result_t;

  localparam state_t STATE_RST = '{
    duty:        8'd0,
    emitting:    1'b0,
    on_since:    32'd0,
    phase:       PH_IDLE,
    phase_start: 32'd0,
    fire_len:    32'd0,
    slew_pan:    POS_HOME,
    slew_tilt:   POS_HOME,
    goal_pan:    POS_HOME,
    goal_tilt:   POS_HOME,
    slew_active: 1'b0,
    slew_period: SLEW_PERIOD_RST,
    last_step:   32'd0,
    servo_pan:   POS_HOME,
    servo_tilt:  POS_HOME
  };

  function automatic logic [6:0] clamp_pos(input logic signed [7:0] v);
    logic [6:0] r;
    if (v < 8'sd0) begin
      r = 7'd0;
    end else if (v > 8'sd100) begin
      r = POS_MAX;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  function automatic logic [6:0] step_toward(input logic [6:0] cur, input logic [6:0] goal);
    logic [6:0] r;
    if (cur < goal) begin
      r = cur + 7'd1;
    end else if (cur > goal) begin
      r = cur - 7'd1;
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

// File: src/laser_fire_sequencer_with_slew.sv
`timescale 1ns / 1ps

// Laser fire sequencer with pan/tilt slew.
// Input channel (in_valid / in_stall) takes one timestamped command word per
// cycle while in_stall is low: tick, set brightness, fire, smooth target or
// aim. Each command word yields exactly one result word on the output
// channel (out_valid / out_stall) carrying laser duty, servo commands, fire
// phase and event flags. The accept edge loads the input register; the
// result register and state load when the word advances, which waits while
// out_stall holds a result. Throughput: one word per cycle while out_stall
// is low; the only loop is the state feedback, through combinational logic.
// When out_stall holds a result, one more word can sit in the input register;
// after that in_stall rises. Results are never dropped or repeated.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 settle time, 1 safety
// timeout) and cfg_wdata; cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous): both channels empty, laser off, sequencer
// idle, servos and slew at home (50), settle 200 ms, timeout 10000 ms.

module laser_fire_sequencer_with_slew import lfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [31:0]       in_now_ms,
  input  logic signed [7:0] in_pan_req,
  input  logic signed [7:0] in_tilt_req,
  input  logic [31:0]       in_duration_ms,
  input  logic [15:0]       in_step_period_ms,
  input  logic [7:0]        in_brightness_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_laser_duty,
  output logic [6:0]        out_pan_cmd,
  output logic [6:0]        out_tilt_cmd,
  output logic              out_servo_written,
  output logic [1:0]        out_fire_state,
  output logic              out_fire_rejected,
  output logic              out_safety_tripped,
  output logic              out_is_emitting,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata
);

  logic        in_full_r, in_full_nxt;
  item_t       item_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r;
  state_t      state_r;
  state_t      state_nxt;
  result_t     res_nxt;
  logic [15:0] settle_r;
  logic [31:0] timeout_r;
  logic        out_free;
  logic        advance;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_full_r && out_free;
  assign in_stall  = in_full_r && !out_free;
  assign accept    = in_valid && !in_stall;

  assign in_full_nxt   = accept || (in_full_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  lfs_step u_step (
    .st         (state_r),
    .item       (item_r),
    .settle_ms  (settle_r),
    .timeout_ms (timeout_r),
    .st_nxt     (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
      settle_r    <= SETTLE_RST;
      timeout_r   <= TIMEOUT_RST;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SETTLE:  settle_r  <= cfg_wdata[15:0];
          CFG_TIMEOUT: timeout_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.req_type       <= in_req_type;
      item_r.now_ms         <= in_now_ms;
      item_r.pan_req        <= in_pan_req;
      item_r.tilt_req       <= in_tilt_req;
      item_r.duration_ms    <= in_duration_ms;
      item_r.step_period_ms <= in_step_period_ms;
      item_r.brightness_req <= in_brightness_req;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_laser_duty     = res_r.laser_duty;
  assign out_pan_cmd        = res_r.pan_cmd;
  assign out_tilt_cmd       = res_r.tilt_cmd;
  assign out_servo_written  = res_r.servo_written;
  assign out_fire_state     = res_r.fire_state;
  assign out_fire_rejected  = res_r.fire_rejected;
  assign out_safety_tripped = res_r.safety_tripped;
  assign out_is_emitting    = res_r.is_emitting;

endmodule

// File: src/lfs_step.sv
`timescale 1ns / 1ps

module lfs_step import lfs_pkg::*; (
  input  state_t      st,
  input  item_t       item,
  input  logic [15:0] settle_ms,
  input  logic [31:0] timeout_ms,
  output state_t      st_nxt,
  output result_t     res
);

  always_comb begin
    state_t     s;
    logic       written;
    logic       rejected;
    logic       tripped;
    logic [6:0] np;
    logic [6:0] nt;
    logic [31:0] now;

    s        = st;
    written  = 1'b0;
    rejected = 1'b0;
    tripped  = 1'b0;
    now      = item.now_ms;
    np       = step_toward(st.slew_pan, st.goal_pan);
    nt       = step_toward(st.slew_tilt, st.goal_tilt);

    case (item.req_type)
      REQ_TICK: begin
        // safety first, then sequencer, then slew
        if (s.emitting && s.duty != 8'd0 && (now - s.on_since) > timeout_ms) begin
          s.duty     = 8'd0;
          s.emitting = 1'b0;
          tripped    = 1'b1;
        end
        if (s.phase == PH_SETTLE) begin
          if ((now - s.phase_start) >= {16'd0, settle_ms}) begin
            s.duty = DUTY_FULL;
            if (!s.emitting) begin
              s.emitting = 1'b1;
              s.on_since = now;
            end
            s.phase       = PH_ON;
            s.phase_start = now;
          end
        end else if (s.phase == PH_ON) begin
          if ((now - s.phase_start) >= s.fire_len) begin
            s.duty     = 8'd0;
            s.emitting = 1'b0;
            s.phase    = PH_IDLE;
          end
        end
        if (s.slew_active && (now - s.last_step) >= {16'd0, s.slew_period}) begin
          s.last_step = now;
          s.slew_pan  = np;
          s.slew_tilt = nt;
          if (np != st.slew_pan || nt != st.slew_tilt) begin
            s.servo_pan  = np;
            s.servo_tilt = nt;
            written      = 1'b1;
          end else begin
            s.slew_active = 1'b0;
          end
        end
      end
      REQ_BRIGHT: begin
        s.duty = item.brightness_req;
        if (item.brightness_req != 8'd0 && !s.emitting) begin
          s.emitting = 1'b1;
          s.on_since = now;
        end else if (item.brightness_req == 8'd0) begin
          s.emitting = 1'b0;
        end
      end
      REQ_FIRE: begin
        if (s.phase != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          s.servo_pan   = clamp_pos(item.pan_req);
          s.servo_tilt  = clamp_pos(item.tilt_req);
          s.fire_len    = (item.duration_ms != 32'd0) ? item.duration_ms : FIRE_DEFAULT;
          written       = 1'b1;
          s.phase       = PH_SETTLE;
          s.phase_start = now;
        end
      end
      REQ_SMOOTH: begin
        s.slew_pan    = s.servo_pan;
        s.slew_tilt   = s.servo_tilt;
        s.goal_pan    = clamp_pos(item.pan_req);
        s.goal_tilt   = clamp_pos(item.tilt_req);
        s.slew_period = (item.step_period_ms < MIN_STEP) ? MIN_STEP : item.step_period_ms;
        s.slew_active = 1'b1;
      end
      REQ_AIM: begin
        s.servo_pan  = clamp_pos(item.pan_req);
        s.servo_tilt = clamp_pos(item.tilt_req);
        written      = 1'b1;
      end
      default: begin
      end
    endcase

    st_nxt             = s;
    res.laser_duty     = s.duty;
    res.pan_cmd        = s.servo_pan;
    res.tilt_cmd       = s.servo_tilt;
    res.servo_written  = written;
    res.fire_state     = s.phase;
    res.fire_rejected  = rejected;
    res.safety_tripped = tripped;
    res.is_emitting    = s.emitting;
  end

endmodule
